### hdl/mcaa_pkg.sv
`default_nettype none
package mcaa_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_SETTLE_DISCARDS = 4'd0;
    localparam logic [3:0] CFG_CHANNELS_IN_USE = 4'd1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_DATA_W-1:0] SETTLE_DISCARDS_RESET = 4'd3;
    localparam logic [CFG_DATA_W-1:0] CHANNELS_IN_USE_RESET = 4'd8;

    // Port field widths
    localparam int SAMPLE_IN_W = 10;
    localparam int CHAN_OUT_W  = 3;
    localparam int VALUE_OUT_W = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

endpackage
`default_nettype wire

### hdl/mcaa_queue.sv
`default_nettype none
module mcaa_queue import mcaa_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### hdl/mcaa_front.sv
`default_nettype none
module mcaa_front import mcaa_pkg::*; #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                   cfg_data,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [SAMPLE_IN_W-1:0]                  s_sample,
    input  wire logic                                    queue_full,
    output logic                                         push,
    output logic                                         item_keep,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] item_channel,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] item_mux_channel,
    output logic [SAMPLE_BITS-1:0]                       item_sample
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACT_W = ($clog2(CHANNELS + 1) > CFG_DATA_W) ?
                           $clog2(CHANNELS + 1) : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] settle_discards_reg;
    logic [CFG_DATA_W-1:0] channels_in_use_reg;
    logic [CH_W-1:0]       current_channel_reg, current_channel_next;
    logic [CFG_DATA_W-1:0] settle_left_reg, settle_left_next;

    logic [ACT_W-1:0] n_raw, n_act, ch_inc;
    logic [CH_W-1:0]  step_channel;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        n_raw = (channels_in_use_reg == '0) ? ACT_W'(1) : ACT_W'(channels_in_use_reg);
        n_act = (n_raw > ACT_W'(CHANNELS)) ? ACT_W'(CHANNELS) : n_raw;
        ch_inc = ACT_W'(current_channel_reg) + ACT_W'(1);
        step_channel = (ch_inc >= n_act) ? '0 : CH_W'(ch_inc);
    end

    // Drop samples while settling; otherwise keep one and advance the mux.
    always_comb begin
        item_keep            = (settle_left_reg == '0);
        item_channel         = current_channel_reg;
        item_sample          = SAMPLE_BITS'(s_sample);
        current_channel_next = current_channel_reg;
        settle_left_next     = settle_left_reg;
        if (item_keep) begin
            current_channel_next = step_channel;
            settle_left_next     = settle_discards_reg;
        end else begin
            settle_left_next = settle_left_reg - CFG_DATA_W'(1);
        end
        item_mux_channel = current_channel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_discards_reg <= SETTLE_DISCARDS_RESET;
            channels_in_use_reg <= CHANNELS_IN_USE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_SETTLE_DISCARDS) begin
                settle_discards_reg <= cfg_data;
            end else if (cfg_index == CFG_CHANNELS_IN_USE) begin
                channels_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_channel_reg <= '0;
            settle_left_reg     <= '0;
        end else if (push) begin
            current_channel_reg <= current_channel_next;
            settle_left_reg     <= settle_left_next;
        end
    end

endmodule
`default_nettype wire

### hdl/mcaa_back.sv
`default_nettype none
module mcaa_back import mcaa_pkg::*; #(
    parameter int CHANNELS            = 8,
    parameter int SAMPLES_PER_AVERAGE = 16,
    parameter int SAMPLE_BITS         = 10
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         pop,
    input  wire logic                                    in_keep,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] in_channel,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] in_mux_channel,
    input  wire logic [SAMPLE_BITS-1:0]                  in_sample,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [CHAN_OUT_W-1:0]                        out_mux_channel,
    output logic                                         out_average_ready,
    output logic [CHAN_OUT_W-1:0]                        out_average_channel,
    output logic [VALUE_OUT_W-1:0]                       out_average_value
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * ((1 << SAMPLE_BITS) - 1) + 1);
    // Reciprocal for the quotient estimate; it is exact or one low.
    localparam logic [SUM_W:0]   DIV_M = (SUM_W + 1)'((1 << SUM_W) / SAMPLES_PER_AVERAGE);
    localparam logic [SUM_W-1:0] SPA_C = SUM_W'(SAMPLES_PER_AVERAGE);
    localparam logic [CNT_W-1:0] SPA_N = CNT_W'(SAMPLES_PER_AVERAGE);

    logic [SUM_W-1:0] sum_reg   [CHANNELS];
    logic [CNT_W-1:0] count_reg [CHANNELS];

    logic [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0] acc_count;
    logic             acc_done;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_next;

    logic             s1_valid_reg;
    logic [CH_W-1:0]  s1_mux_reg, s1_ch_reg;
    logic             s1_done_reg;
    logic [SUM_W-1:0] s1_sum_reg;

    logic             s2_valid_reg;
    logic [CH_W-1:0]  s2_mux_reg, s2_ch_reg;
    logic             s2_done_reg;
    logic [SUM_W-1:0] s2_sum_reg, s2_q0_reg;

    logic                   out_valid_reg;
    logic [CHAN_OUT_W-1:0]  out_mux_reg, out_ch_reg;
    logic                   out_done_reg;
    logic [VALUE_OUT_W-1:0] out_val_reg;

    logic               s1_ready, s2_ready, s3_ready;
    logic [2*SUM_W:0]   est_prod;
    logic [SUM_W-1:0]   q0;
    logic [SUM_W-1:0]   q0_times;
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   quotient;

    assign s3_ready = !out_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = in_valid && s1_ready;

    // Read-modify-write of the selected channel's sum and count
    always_comb begin
        acc_sum    = sum_reg[in_channel] + SUM_W'(in_sample);
        acc_count  = count_reg[in_channel] + CNT_W'(1);
        acc_done   = in_keep && (acc_count >= SPA_N);
        sum_next   = acc_done ? '0 : acc_sum;
        count_next = acc_done ? '0 : acc_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else if (pop && in_keep) begin
            sum_reg[in_channel]   <= sum_next;
            count_reg[in_channel] <= count_next;
        end
    end

    assign est_prod = (2 * SUM_W + 1)'(s1_sum_reg) * (2 * SUM_W + 1)'(DIV_M);
    assign q0       = est_prod[2*SUM_W-1:SUM_W];

    // Correct the estimate by one where the remainder still holds a divisor
    always_comb begin
        q0_times = s2_q0_reg * SPA_C;
        rem      = s2_sum_reg - q0_times;
        quotient = (rem >= SPA_C) ? s2_q0_reg + SUM_W'(1) : s2_q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= pop;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_mux_reg  <= in_mux_channel;
            s1_ch_reg   <= in_channel;
            s1_done_reg <= acc_done;
            s1_sum_reg  <= acc_sum;
        end
        if (s2_ready) begin
            s2_mux_reg  <= s1_mux_reg;
            s2_ch_reg   <= s1_ch_reg;
            s2_done_reg <= s1_done_reg;
            s2_sum_reg  <= s1_sum_reg;
            s2_q0_reg   <= q0;
        end
        if (s3_ready) begin
            out_mux_reg  <= CHAN_OUT_W'(s2_mux_reg);
            out_done_reg <= s2_done_reg;
            out_ch_reg   <= s2_done_reg ? CHAN_OUT_W'(s2_ch_reg) : '0;
            out_val_reg  <= s2_done_reg ? VALUE_OUT_W'(quotient) : '0;
        end
    end

    assign m_valid             = out_valid_reg;
    assign out_mux_channel     = out_mux_reg;
    assign out_average_ready   = out_done_reg;
    assign out_average_channel = out_ch_reg;
    assign out_average_value   = out_val_reg;

endmodule
`default_nettype wire

### hdl/multichannel_adc_averager.sv
// An accepted sample's result passes the queue, then the s1, s2 and output registers.
// Throughput: one sample per cycle while m_tready keeps up, set by the read-modify-write of the
// per-channel sum and count; the queue, s1 and s2 take further samples while a result waits.
// Reset (aresetn, synchronous, active low): all channel sums and counts clear at once,
// the scan restarts at channel 0 with no settle pending, settle_discards = 3, channels_in_use = 8.
`default_nettype none
module multichannel_adc_averager import mcaa_pkg::*; #(
    parameter int CHANNELS            = 8,
    parameter int SAMPLES_PER_AVERAGE = 16,
    parameter int SAMPLE_BITS         = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [9:0] sample, [15:10] zero
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [2:0] next_mux_channel,
                                                   // [5:3] average_channel,
                                                   // [15:6] average_value
    output logic                        m_tuser    // [0] average_ready
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ITEM_W = 1 + 2 * CH_W + SAMPLE_BITS;

    logic                   queue_full, queue_not_empty;
    logic                   push, pop;
    logic                   f_keep;
    logic [CH_W-1:0]        f_channel, f_mux_channel;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [ITEM_W-1:0]      push_data, pop_data;

    logic                   b_keep;
    logic [CH_W-1:0]        b_channel, b_mux_channel;
    logic [SAMPLE_BITS-1:0] b_sample;

    logic [CHAN_OUT_W-1:0]  mux_out, avg_ch_out;
    logic [VALUE_OUT_W-1:0] avg_val_out;

    mcaa_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_sample         (s_tdata[SAMPLE_IN_W-1:0]),
        .queue_full       (queue_full),
        .push             (push),
        .item_keep        (f_keep),
        .item_channel     (f_channel),
        .item_mux_channel (f_mux_channel),
        .item_sample      (f_sample)
    );

    assign push_data = {f_keep, f_channel, f_mux_channel, f_sample};

    mcaa_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    assign {b_keep, b_channel, b_mux_channel, b_sample} = pop_data;

    mcaa_back #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SAMPLE_BITS         (SAMPLE_BITS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (queue_not_empty),
        .pop                 (pop),
        .in_keep             (b_keep),
        .in_channel          (b_channel),
        .in_mux_channel      (b_mux_channel),
        .in_sample           (b_sample),
        .m_valid             (m_tvalid),
        .m_ready             (m_tready),
        .out_mux_channel     (mux_out),
        .out_average_ready   (m_tuser),
        .out_average_channel (avg_ch_out),
        .out_average_value   (avg_val_out)
    );

    assign m_tdata = {avg_val_out, avg_ch_out, mux_out};

endmodule
`default_nettype wire

### verif/mcaa_result_checker.sv
`default_nettype none
module mcaa_result_checker import mcaa_pkg::*; #(
    parameter int CHANNELS            = 8,
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   m_tuser,
    output int                          error_count,
    output int                          outstanding
);

    typedef struct packed {
        logic [CHAN_OUT_W-1:0]  next_chan;
        logic                   avg_ready;
        logic [CHAN_OUT_W-1:0]  avg_chan;
        logic [VALUE_OUT_W-1:0] avg_value;
    } scan_result_t;

    scan_result_t expected_scans[$];

    // Shadow of the block's registers and scan state
    logic [CFG_DATA_W-1:0] settle_setting;
    logic [CFG_DATA_W-1:0] chan_setting;
    int scan_chan;
    int settle_left;
    int chan_sum   [CHANNELS];
    int chan_count [CHANNELS];

    int mismatches = 0;
    int pending_n  = 0;

    assign error_count = mismatches;
    assign outstanding = pending_n;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic scan_result_t predict_scan(input logic [SAMPLE_IN_W-1:0] sample);
        scan_result_t r;
        int ch;
        int n_active;
        r = '0;
        if (settle_left != 0) begin
            settle_left--;
        end else begin
            ch = (scan_chan >= CHANNELS) ? 0 : scan_chan;
            chan_sum[ch]   += sample;
            chan_count[ch] += 1;
            if (chan_count[ch] >= SAMPLES_PER_AVERAGE) begin
                r.avg_ready    = 1'b1;
                r.avg_chan     = CHAN_OUT_W'(ch);
                r.avg_value    = VALUE_OUT_W'(chan_sum[ch] / SAMPLES_PER_AVERAGE);
                chan_sum[ch]   = 0;
                chan_count[ch] = 0;
            end
            // clamp the scan width to 1..CHANNELS
            n_active = chan_setting;
            if (n_active == 0)
                n_active = 1;
            if (n_active > CHANNELS)
                n_active = CHANNELS;
            scan_chan   = (ch + 1 >= n_active) ? 0 : ch + 1;
            settle_left = settle_setting;
        end
        r.next_chan = CHAN_OUT_W'(scan_chan);
        return r;
    endfunction

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            settle_setting = SETTLE_DISCARDS_RESET;
            chan_setting   = CHANNELS_IN_USE_RESET;
            scan_chan      = 0;
            settle_left    = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                chan_sum[i]   = 0;
                chan_count[i] = 0;
            end
            expected_scans.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_scans.size() == 0) begin
                    report_mismatch("result with no sample pending", m_tdata, -1);
                end else begin
                    want = expected_scans.pop_front();
                    if (m_tdata[2:0] !== want.next_chan)
                        report_mismatch("next_mux_channel", m_tdata[2:0], want.next_chan);
                    if (m_tuser !== want.avg_ready)
                        report_mismatch("average_ready", m_tuser, want.avg_ready);
                    if (m_tdata[5:3] !== want.avg_chan)
                        report_mismatch("average_channel", m_tdata[5:3], want.avg_chan);
                    if (m_tdata[15:6] !== want.avg_value)
                        report_mismatch("average_value", m_tdata[15:6], want.avg_value);
                end
            end
            // A sample accepted on the same edge as a write still sees the old registers
            if (s_tvalid && s_tready)
                expected_scans.push_back(predict_scan(s_tdata[SAMPLE_IN_W-1:0]));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SETTLE_DISCARDS: settle_setting = cfg_data;
                    CFG_CHANNELS_IN_USE: chan_setting   = cfg_data;
                    default: ;
                endcase
            end
        end
        pending_n = expected_scans.size();
    end

endmodule
`default_nettype wire

### verif/multichannel_adc_averager_tb.sv
`default_nettype none
module multichannel_adc_averager_tb import mcaa_pkg::*;;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASES           = 12;
    localparam int PHASE_SAMPLES    = 50;
    localparam logic [SAMPLE_IN_W-1:0] SAMPLE_MAX = '1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNMAPPED = 4'hF;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_ALTERNATE} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    int          error_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_ack = 1'b0;

    multichannel_adc_averager u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mcaa_result_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("multichannel_adc_averager_tb: FAIL");
        $finish;
    end

    // Result side: own stall pattern, plus a long hold-off on request
    initial begin
        rx_mode_t rx_mode;
        int       rx_left;
        bit       rx_toggle;
        rx_mode   = RX_ALWAYS;
        rx_left   = 0;
        rx_toggle = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req != hold_off_ack) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_off_ack = hold_off_req;
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            rx_toggle = ~rx_toggle;
            case (rx_mode)
                RX_ALWAYS:    m_tready <= 1'b1;
                RX_MOSTLY:    m_tready <= ($urandom_range(0, 3) != 0);
                RX_RARELY:    m_tready <= ($urandom_range(0, 3) == 0);
                RX_ALTERNATE: m_tready <= rx_toggle;
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Leaves tvalid high so back-to-back transactions need no gap
    task automatic send_sample(input logic [SAMPLE_IN_W-1:0] sample);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(sample);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_IN_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_IN_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    initial begin
        int burst_left;
        int gap;
        bit no_idle;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default registers: first sample kept, then three dropped while settling
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_IN_W'(10'h155));
        send_sample(SAMPLE_IN_W'(10'h2AA));
        wait_results_drained();

        // Zero channels acts as one; the scan sits on channel 1, beyond the count
        write_reg(CFG_INDEX_UNMAPPED, '1);
        write_reg(CFG_CHANNELS_IN_USE, '0);
        write_reg(CFG_SETTLE_DISCARDS, '0);
        repeat (16) send_sample(SAMPLE_MAX);
        wait_results_drained();

        // Oversized channel count clamps to the full scan; longest settle
        write_reg(CFG_CHANNELS_IN_USE, '1);
        write_reg(CFG_SETTLE_DISCARDS, '1);
        repeat (4) send_sample(random_sample());
        wait_results_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SETTLE_DISCARDS, 4'd0);
                    write_reg(CFG_CHANNELS_IN_USE, 4'd1);
                end
                1: begin
                    write_reg(CFG_SETTLE_DISCARDS, 4'd15);
                    write_reg(CFG_CHANNELS_IN_USE, 4'd8);
                end
                2: begin
                    write_reg(CFG_SETTLE_DISCARDS, 4'd0);
                    write_reg(CFG_CHANNELS_IN_USE, 4'd8);
                end
                default: begin
                    write_reg(CFG_SETTLE_DISCARDS, ($urandom_range(0, 3) == 0) ?
                              CFG_DATA_W'($urandom_range(0, 15)) :
                              CFG_DATA_W'($urandom_range(0, 2)));
                    write_reg(CFG_CHANNELS_IN_USE, CFG_DATA_W'($urandom_range(0, 15)));
                end
            endcase

            // Stall the result side for a long stretch while samples keep coming
            if (phase == 3 || phase == 9)
                hold_off_req = ~hold_off_req;
            no_idle    = (phase % 4 == 3) || (phase == 2);
            burst_left = $urandom_range(1, 20);
            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                                                        $urandom_range(0, 3);
                    if (gap > 0 && !no_idle)
                        sender_gap(gap);
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                send_sample(random_sample());
                if (k == PHASE_SAMPLES / 2 && phase % 3 == 1)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("multichannel_adc_averager_tb: PASS");
        else
            $display("multichannel_adc_averager_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
